>>> src/cartesian_polar_converter_core_assert.svh
// assertion macros used by the converter top level
`ifndef CARTESIAN_POLAR_CONVERTER_CORE_ASSERT_SVH
`define CARTESIAN_POLAR_CONVERTER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CPC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CPC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cpc_pkg.sv
// shared constants, types and tables of the coordinate converter
`timescale 1ns / 1ps

package cpc_pkg;

  // mode codes carried in tuser
  localparam logic KIND_TO_POLAR = 1'b0;
  localparam logic KIND_TO_CART  = 1'b1;

  // fraction bits kept below the coordinate lsb
  localparam int GUARD = 8;
  // angle accumulator: 32-bit turns plus a sign bit
  localparam int ZW = 33;
  // gain constant in q30
  localparam int K_FRAC = 30;
  localparam int KW = 30;
  localparam logic [31:0] K_INF_Q30  = 32'd652032874;
  localparam logic [31:0] K_CORR_Q30 = 32'd434688583;
  // split point of the gain multiply
  localparam int GAIN_LO = 20;
  // longest table the unit supports
  localparam int MAX_STEPS = 32;

  // atan(2^-i) in 32-bit turns
  localparam logic [31:0] ATAN_TURNS [MAX_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // control that travels with each request through the pipe
  typedef struct packed {
    logic valid;
    logic kind;
    logic origin;
  } ctrl_t;

  // inverse cordic gain for a given number of iterations
  function automatic logic [KW-1:0] gain_k(input int steps);
    logic [31:0] k;
    k = K_INF_Q30;
    if (2 * steps < 31) begin
      k = k + (K_CORR_Q30 >> (2 * steps));
    end
    return k[KW-1:0];
  endfunction

endpackage

>>> src/cpc_pre.sv
// input conditioning: quadrant fold and scaling into the internal format
`timescale 1ns / 1ps

module cpc_pre #(
  parameter int CB = 16,
  parameter int W  = 27
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic                      kind_i,
  input  logic signed [CB-1:0]      a_i,
  input  logic signed [CB-1:0]      b_i,
  output cpc_pkg::ctrl_t            ctrl_o,
  output logic signed [W-1:0]       x_o,
  output logic signed [W-1:0]       y_o,
  output logic [cpc_pkg::ZW-1:0]    z_o
);

  localparam int ASH = 32 - CB;

  logic signed [CB:0]          a_ext, b_ext, a_neg, b_neg;
  logic signed [CB:0]          x_sel, y_sel;
  logic [31:0]                 t_raw, t_fold;
  logic                        flip;
  cpc_pkg::ctrl_t              ctrl_d, ctrl_q;
  logic signed [W-1:0]         x_d, y_d, x_q, y_q;
  logic [cpc_pkg::ZW-1:0]      z_d, z_q;

  // fold the point or angle into the right half plane
  always_comb begin
    a_ext  = {a_i[CB-1], a_i};
    b_ext  = {b_i[CB-1], b_i};
    a_neg  = -a_ext;
    b_neg  = -b_ext;
    t_raw  = 32'(b_i) << ASH;
    flip   = (t_raw[31:30] == 2'b01) || (t_raw[31:30] == 2'b10);
    t_fold = {t_raw[31] ^ flip, t_raw[30:0]};
    if (kind_i == cpc_pkg::KIND_TO_POLAR) begin
      x_sel = a_i[CB-1] ? a_neg : a_ext;
      y_sel = a_i[CB-1] ? b_neg : b_ext;
      z_d   = a_i[CB-1] ? {2'b01, 31'd0} : '0;
    end else begin
      x_sel = flip ? a_neg : a_ext;
      y_sel = '0;
      z_d   = {t_fold[31], t_fold};
    end
    x_d = W'(x_sel) <<< cpc_pkg::GUARD;
    y_d = W'(y_sel) <<< cpc_pkg::GUARD;
    ctrl_d.valid  = valid_i;
    ctrl_d.kind   = kind_i;
    ctrl_d.origin = (kind_i == cpc_pkg::KIND_TO_POLAR) && (a_i == '0) && (b_i == '0);
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  // data register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

>>> src/cpc_gain.sv
// two-stage gain correction of x, applied only for one mode
`timescale 1ns / 1ps

module cpc_gain #(
  parameter int   W          = 27,
  parameter int   STEPS      = 16,
  parameter logic APPLY_KIND = 1'b0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  cpc_pkg::ctrl_t            ctrl_i,
  input  logic signed [W-1:0]       x_i,
  input  logic signed [W-1:0]       y_i,
  input  logic [cpc_pkg::ZW-1:0]    z_i,
  output cpc_pkg::ctrl_t            ctrl_o,
  output logic signed [W-1:0]       x_o,
  output logic signed [W-1:0]       y_o,
  output logic [cpc_pkg::ZW-1:0]    z_o
);

  localparam int AW = (W > cpc_pkg::GAIN_LO) ? W : cpc_pkg::GAIN_LO + 1;
  localparam int HW = AW - cpc_pkg::GAIN_LO;
  localparam int PHW = HW + cpc_pkg::KW;
  localparam int PLW = cpc_pkg::GAIN_LO + cpc_pkg::KW;
  localparam int SW = AW + cpc_pkg::KW + 1;
  localparam logic [cpc_pkg::KW-1:0] K = cpc_pkg::gain_k(STEPS);
  localparam logic [SW-1:0] RND = SW'(1) << (cpc_pkg::K_FRAC - 1);

  logic                          neg;
  logic [W-1:0]                  mag;
  logic [AW-1:0]                 mag_ext;
  logic [HW-1:0]                 hi;
  logic [cpc_pkg::GAIN_LO-1:0]   lo;

  cpc_pkg::ctrl_t                ctrl_a_q, ctrl_b_q;
  logic [PHW-1:0]                p_hi_q;
  logic [PLW-1:0]                p_lo_q;
  logic                          neg_a_q;
  logic signed [W-1:0]           x_a_q, y_a_q, x_b_q, y_b_q;
  logic [cpc_pkg::ZW-1:0]        z_a_q, z_b_q;

  logic [SW-1:0]                 sum;
  logic [W-1:0]                  rmag;
  logic signed [W-1:0]           x_g;

  // magnitude split into two partial products
  always_comb begin
    neg     = x_i[W-1];
    mag     = neg ? W'(-x_i) : W'(x_i);
    mag_ext = AW'(mag);
    hi      = mag_ext[AW-1:cpc_pkg::GAIN_LO];
    lo      = mag_ext[cpc_pkg::GAIN_LO-1:0];
  end

  // combine partial products, round half up, restore sign
  always_comb begin
    sum  = (SW'(p_hi_q) << cpc_pkg::GAIN_LO) + SW'(p_lo_q) + RND;
    rmag = W'(sum[SW-1:cpc_pkg::K_FRAC]);
    x_g  = neg_a_q ? signed'(-rmag) : signed'(rmag);
  end

  // control registers of both stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_b_q <= '0;
    end else if (en_i) begin
      ctrl_a_q <= ctrl_i;
      ctrl_b_q <= ctrl_a_q;
    end
  end

  // data registers of both stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_hi_q  <= PHW'(hi) * PHW'(K);
      p_lo_q  <= PLW'(lo) * PLW'(K);
      neg_a_q <= neg;
      x_a_q   <= x_i;
      y_a_q   <= y_i;
      z_a_q   <= z_i;
      x_b_q   <= (ctrl_a_q.kind == APPLY_KIND) ? x_g : x_a_q;
      y_b_q   <= y_a_q;
      z_b_q   <= z_a_q;
    end
  end

  assign ctrl_o = ctrl_b_q;
  assign x_o    = x_b_q;
  assign y_o    = y_b_q;
  assign z_o    = z_b_q;

endmodule

>>> src/cpc_stage.sv
// one registered cordic iteration, vectoring or rotation by mode
`timescale 1ns / 1ps

module cpc_stage #(
  parameter int W = 27,
  parameter int I = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  cpc_pkg::ctrl_t            ctrl_i,
  input  logic signed [W-1:0]       x_i,
  input  logic signed [W-1:0]       y_i,
  input  logic [cpc_pkg::ZW-1:0]    z_i,
  output cpc_pkg::ctrl_t            ctrl_o,
  output logic signed [W-1:0]       x_o,
  output logic signed [W-1:0]       y_o,
  output logic [cpc_pkg::ZW-1:0]    z_o
);

  localparam logic [cpc_pkg::ZW-1:0] ATAN = {1'b0, cpc_pkg::ATAN_TURNS[I]};

  logic signed [W-1:0]       xs, ys, x_d, y_d, x_q, y_q;
  logic [cpc_pkg::ZW-1:0]    z_d, z_q;
  logic                      cw;
  cpc_pkg::ctrl_t            ctrl_q;

  // vectoring drives y to zero, rotation drives z to zero
  always_comb begin
    xs = x_i >>> I;
    ys = y_i >>> I;
    if (ctrl_i.kind == cpc_pkg::KIND_TO_POLAR) begin
      cw = !y_i[W-1];
    end else begin
      cw = z_i[cpc_pkg::ZW-1];
    end
    if (cw) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // data register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

>>> src/cpc_post.sv
// output rounding, angle scaling and saturation
`timescale 1ns / 1ps

module cpc_post #(
  parameter int CB = 16,
  parameter int W  = 27
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  cpc_pkg::ctrl_t            ctrl_i,
  input  logic signed [W-1:0]       x_i,
  input  logic signed [W-1:0]       y_i,
  input  logic [cpc_pkg::ZW-1:0]    z_i,
  output cpc_pkg::ctrl_t            ctrl_o,
  output logic signed [CB:0]        a_o,
  output logic signed [CB-1:0]      b_o
);

  localparam int ASH = 32 - CB;
  localparam logic signed [W-1:0] RND = W'(1 << (cpc_pkg::GUARD - 1));
  localparam logic signed [W-1:0] HALF_P = {{(W - CB){1'b0}}, 1'b1, {(CB - 1){1'b0}}};
  localparam logic signed [W-1:0] HALF_N = W'(-HALF_P);
  localparam logic signed [W-1:0] HALF_M = W'(HALF_P - 1);
  localparam logic [32:0] ARND = (33'd1 << ASH) >> 1;

  logic signed [W-1:0]     xl, yl, xc, yc;
  logic [32:0]             zsum;
  logic signed [CB:0]      a_d, a_q;
  logic signed [CB-1:0]    b_d, b_q;
  cpc_pkg::ctrl_t          ctrl_q;

  // leave the internal format and pick the mode's results
  always_comb begin
    xl   = (x_i + RND) >>> cpc_pkg::GUARD;
    yl   = (y_i + RND) >>> cpc_pkg::GUARD;
    xc   = (xl > HALF_P) ? HALF_P : ((xl < HALF_N) ? HALF_N : xl);
    yc   = (yl > HALF_M) ? HALF_M : ((yl < HALF_N) ? HALF_N : yl);
    zsum = {1'b0, z_i[31:0]} + ARND;
    if (ctrl_i.kind == cpc_pkg::KIND_TO_POLAR) begin
      if (ctrl_i.origin) begin
        a_d = '0;
        b_d = '0;
      end else begin
        a_d = xl[CB:0];
        b_d = zsum[ASH +: CB];
      end
    end else begin
      a_d = xc[CB:0];
      b_d = yc[CB-1:0];
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;

endmodule

>>> src/cartesian_polar_converter_core.sv
// Cartesian/polar coordinate converter, pipelined unrolled CORDIC.
// Slave stream: tuser carries the mode (0 = cartesian to polar, 1 = polar
// to cartesian); tdata carries in_a (x or radius) and in_b (y or angle).
// Master stream: tdata carries out_a (magnitude or x) and out_b (angle or y).
// Angles are binary: 2^(COORD_BITS-1) stands for pi.
// Stages: one input stage, two gain stages ahead of the iterations, one
// register per CORDIC iteration, two gain stages behind, one rounding
// stage and the output register.
// Throughput is one request per cycle while the skid register is empty;
// every stage is its own register, so a new request enters each cycle unless the pipe is frozen.
// When the receiver stalls, the output register holds its result and a
// skid register catches the one behind it; only then does s_axis_tready
// drop and the whole pipe freeze, so nothing is lost or repeated.
// Reset clears all valid bits; the block takes requests right after.
`timescale 1ns / 1ps

`include "cartesian_polar_converter_core_assert.svh"

module cartesian_polar_converter_core #(
  parameter int COORD_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // in_a, in_b
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // kind
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // out_a, out_b
  output logic [((2*COORD_BITS+8)/8)*8-1:0]      m_axis_tdata
);

  localparam int CB    = COORD_BITS;
  localparam int STEPS = (CORDIC_STEPS > cpc_pkg::MAX_STEPS) ? cpc_pkg::MAX_STEPS
                                                               : CORDIC_STEPS;
  localparam int W     = CB + cpc_pkg::GUARD + 3;
  localparam int ODW   = ((2 * CB + 8) / 8) * 8;

  logic                      pipe_en;

  cpc_pkg::ctrl_t            pre_ctrl, g1_ctrl, g2_ctrl, post_ctrl;
  logic signed [W-1:0]       pre_x, pre_y, g1_x, g1_y, g2_x, g2_y;
  logic [cpc_pkg::ZW-1:0]    pre_z, g1_z, g2_z;

  cpc_pkg::ctrl_t            st_ctrl [STEPS+1];
  logic signed [W-1:0]       st_x [STEPS+1];
  logic signed [W-1:0]       st_y [STEPS+1];
  logic [cpc_pkg::ZW-1:0]    st_z [STEPS+1];

  logic signed [CB:0]        post_a;
  logic signed [CB-1:0]      post_b;

  logic                      out_valid_q, skid_valid_q;
  logic signed [CB:0]        out_a_q, skid_a_q;
  logic signed [CB-1:0]      out_b_q, skid_b_q;

  // the pipe moves unless the skid register is occupied
  assign pipe_en       = !skid_valid_q;
  assign s_axis_tready = pipe_en;

  // input conditioning
  cpc_pre #(
    .CB (CB),
    .W  (W)
  ) u_pre (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid),
    .kind_i  (s_axis_tuser),
    .a_i     (s_axis_tdata[CB-1:0]),
    .b_i     (s_axis_tdata[2*CB-1:CB]),
    .ctrl_o  (pre_ctrl),
    .x_o     (pre_x),
    .y_o     (pre_y),
    .z_o     (pre_z)
  );

  // radius prescale for rotation
  cpc_gain #(
    .W          (W),
    .STEPS      (STEPS),
    .APPLY_KIND (cpc_pkg::KIND_TO_CART)
  ) u_gain_pre (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .ctrl_i (pre_ctrl),
    .x_i    (pre_x),
    .y_i    (pre_y),
    .z_i    (pre_z),
    .ctrl_o (g1_ctrl),
    .x_o    (g1_x),
    .y_o    (g1_y),
    .z_o    (g1_z)
  );

  assign st_ctrl[0] = g1_ctrl;
  assign st_x[0]    = g1_x;
  assign st_y[0]    = g1_y;
  assign st_z[0]    = g1_z;

  // unrolled iterations
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    cpc_stage #(
      .W (W),
      .I (i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .ctrl_i (st_ctrl[i]),
      .x_i    (st_x[i]),
      .y_i    (st_y[i]),
      .z_i    (st_z[i]),
      .ctrl_o (st_ctrl[i+1]),
      .x_o    (st_x[i+1]),
      .y_o    (st_y[i+1]),
      .z_o    (st_z[i+1])
    );
  end

  // magnitude scale for vectoring
  cpc_gain #(
    .W          (W),
    .STEPS      (STEPS),
    .APPLY_KIND (cpc_pkg::KIND_TO_POLAR)
  ) u_gain_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .ctrl_i (st_ctrl[STEPS]),
    .x_i    (st_x[STEPS]),
    .y_i    (st_y[STEPS]),
    .z_i    (st_z[STEPS]),
    .ctrl_o (g2_ctrl),
    .x_o    (g2_x),
    .y_o    (g2_y),
    .z_o    (g2_z)
  );

  // rounding and saturation
  cpc_post #(
    .CB (CB),
    .W  (W)
  ) u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .ctrl_i (g2_ctrl),
    .x_i    (g2_x),
    .y_i    (g2_y),
    .z_i    (g2_z),
    .ctrl_o (post_ctrl),
    .a_o    (post_a),
    .b_o    (post_b)
  );

  // output register and skid valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (m_axis_tready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= post_ctrl.valid;
      end
    end else if (pipe_en && post_ctrl.valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output register and skid payload
  always_ff @(posedge clk_i) begin
    if (m_axis_tready || !out_valid_q) begin
      if (skid_valid_q) begin
        out_a_q <= skid_a_q;
        out_b_q <= skid_b_q;
      end else begin
        out_a_q <= post_a;
        out_b_q <= post_b;
      end
    end else if (pipe_en) begin
      skid_a_q <= post_a;
      skid_b_q <= post_b;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = ODW'({out_b_q, out_a_q});

  // skid only ever fills behind a waiting result
  `CPC_ASSERT_SAME(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q, "skid full with empty output")
  // a stalled output catches the arriving result in the skid
  `CPC_ASSERT_NEXT(a_skid_catch, clk_i, rst_ni, out_valid_q && !m_axis_tready && !skid_valid_q && post_ctrl.valid, skid_valid_q, "result dropped on stall")
  // a taken result lets the skid drain into the output
  `CPC_ASSERT_NEXT(a_skid_drain, clk_i, rst_ni, skid_valid_q && m_axis_tready, out_valid_q && !skid_valid_q, "skid did not drain")

endmodule
